FILE: hdl/tcsb_pkg.sv
// Shared types and constants for the text cell sprite blitter.
package tcsb_pkg;

  // Cell word: character in the upper bits, attribute byte in the lower bits
  localparam int unsigned CHAR_W  = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned WORD_W  = CHAR_W + COLOR_W;

  // Item op codes
  localparam logic [1:0] OP_BLIT  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Render modes
  localparam logic [1:0] MODE_OPAQUE     = 2'd0;
  localparam logic [1:0] MODE_SKIP_PCT   = 2'd1;
  localparam logic [1:0] MODE_SKIP_SPACE = 2'd2;

  // Transparent character codes
  localparam logic [15:0] CHAR_PERCENT = 16'h0025;
  localparam logic [15:0] CHAR_SPACE   = 16'h0020;

  // Configuration register indexes
  localparam logic [2:0] CFG_DEST_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_DEST_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_SOURCE_WIDTH = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_X     = 3'd3;
  localparam logic [2:0] CFG_ORIGIN_Y     = 3'd4;
  localparam logic [2:0] CFG_RENDER_MODE  = 3'd5;
  localparam logic [2:0] CFG_FG_ONLY      = 3'd6;

  // Configuration reset values
  localparam logic [7:0]        RST_DEST_WIDTH   = 8'd80;
  localparam logic [6:0]        RST_DEST_HEIGHT  = 7'd25;
  localparam logic [7:0]        RST_SOURCE_WIDTH = 8'd1;
  localparam logic signed [8:0] RST_ORIGIN_X     = 9'sd1;
  localparam logic signed [8:0] RST_ORIGIN_Y     = 9'sd1;

  // What the back end does with a queued item
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_BLIT,
    KIND_POINT,
    KIND_READ
  } kind_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    kind_t                kind;
    logic                 wr;
    logic                 clip;
    logic                 fg_only;
    logic [CHAR_W-1:0]    chr;
    logic [COLOR_W-1:0]   color;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic                 clipped;
    logic                 written;
    logic [COLOR_W-1:0]   read_color;
    logic [CHAR_W-1:0]    read_char;
  } res_t;

endpackage

FILE: hdl/tcsb_ram.sv
// Generic single write port, single read port RAM with registered read.
module tcsb_ram import tcsb_pkg::*; #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tcsb_queue.sv
// Short FIFO between the front end and the back end.
module tcsb_queue import tcsb_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != (PW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/tcsb_front.sv
// Front end: configuration registers, blit counters, placement and clipping.
module tcsb_front import tcsb_pkg::*; #(
  parameter int STORE_CELLS = 8192,
  parameter int MAX_COLUMNS = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [8:0]                     cfg_data,
  // incoming items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [CHAR_W-1:0]              cell_char,
  input  logic [COLOR_W-1:0]             cell_color,
  input  logic                           last_cell,
  input  logic signed [8:0]              point_x,
  input  logic signed [8:0]              point_y,
  input  logic [12:0]                    read_index,
  input  logic                           hold,
  // classified items toward the queue
  output logic                           q_valid,
  input  logic                           q_ready,
  output cmd_t                           q_cmd,
  output logic [$clog2(STORE_CELLS)-1:0] q_addr
);

  localparam int AW = $clog2(STORE_CELLS);
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int TW = ((CW > 9) ? CW : 9) + 2;

  logic [7:0]        dest_width;
  logic [6:0]        dest_height;
  logic [7:0]        source_width;
  logic signed [8:0] origin_x;
  logic signed [8:0] origin_y;
  logic [1:0]        render_mode;
  logic              foreground_only;

  logic [CW-1:0]     column;
  logic [7:0]        row;
  logic [CW-1:0]     column_next;
  logic [7:0]        row_next;

  logic [CW:0]          sw_eff;
  logic [CW:0]          col_inc;
  logic signed [TW-1:0] tx;
  logic signed [TW-1:0] ty;
  logic [TW-1:0]        ux;
  logic [TW-1:0]        uy;
  logic [7:0]           xm1;
  logic [6:0]           dy;
  logic [14:0]          prod;
  logic [15:0]          lin;
  logic                 on_screen;
  logic                 loc_ok;
  logic                 rd_ok;
  logic                 skip;
  logic                 fire;

  assign in_ready = q_ready && !hold;
  assign q_valid  = in_valid && !hold;
  assign fire     = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width      <= RST_DEST_WIDTH;
      dest_height     <= RST_DEST_HEIGHT;
      source_width    <= RST_SOURCE_WIDTH;
      origin_x        <= RST_ORIGIN_X;
      origin_y        <= RST_ORIGIN_Y;
      render_mode     <= MODE_OPAQUE;
      foreground_only <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEST_WIDTH:   dest_width      <= cfg_data[7:0];
        CFG_DEST_HEIGHT:  dest_height     <= cfg_data[6:0];
        CFG_SOURCE_WIDTH: source_width    <= cfg_data[7:0];
        CFG_ORIGIN_X:     origin_x        <= $signed(cfg_data);
        CFG_ORIGIN_Y:     origin_y        <= $signed(cfg_data);
        CFG_RENDER_MODE:  render_mode     <= cfg_data[1:0];
        CFG_FG_ONLY:      foreground_only <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Effective source width: zero acts as one, clamp to the column limit
  always_comb begin
    if (source_width == 8'd0) begin
      sw_eff = (CW+1)'(1);
    end else if (32'(source_width) > MAX_COLUMNS) begin
      sw_eff = (CW+1)'(MAX_COLUMNS);
    end else begin
      sw_eff = (CW+1)'(source_width);
    end
  end

  // Counter advance after each blit item
  assign col_inc = {1'b0, column} + 1'b1;

  always_comb begin
    column_next = column;
    row_next    = row;
    if (fire && (op == OP_BLIT)) begin
      if (last_cell) begin
        column_next = '0;
        row_next    = '0;
      end else if (col_inc >= sw_eff) begin
        column_next = '0;
        row_next    = (row == 8'd255) ? row : row + 1'b1;
      end else begin
        column_next = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else begin
      column <= column_next;
      row    <= row_next;
    end
  end

  // Target position: counters for a blit, the point fields otherwise
  always_comb begin
    if (op == OP_BLIT) begin
      tx = TW'(origin_x) + $signed(TW'(column));
      ty = TW'(origin_y) - $signed(TW'(row));
    end else begin
      tx = TW'(point_x);
      ty = TW'(point_y);
    end
  end

  // Clip against the destination and the store, then linear index
  assign ux        = $unsigned(tx);
  assign uy        = $unsigned(ty);
  assign on_screen = !tx[TW-1] && (ux != '0) && !ty[TW-1] && (uy != '0) &&
                     (ux <= TW'(dest_width)) && (uy <= TW'(dest_height));
  assign xm1       = 8'(ux - 1'b1);
  assign dy        = 7'(TW'(dest_height) - uy);
  assign prod      = 15'(dest_width) * 15'(dy);
  assign lin       = 16'(prod) + 16'(xm1);
  assign loc_ok    = on_screen && (32'(lin) < STORE_CELLS);
  assign rd_ok     = (32'(read_index) < STORE_CELLS);

  assign skip = ((render_mode == MODE_SKIP_PCT)   && (cell_char == CHAR_PERCENT)) ||
                ((render_mode == MODE_SKIP_SPACE) && (cell_char == CHAR_SPACE));

  // Classify the item for the back end
  always_comb begin
    q_cmd.kind    = KIND_NOP;
    q_cmd.wr      = 1'b0;
    q_cmd.clip    = 1'b0;
    q_cmd.fg_only = foreground_only;
    q_cmd.chr     = cell_char;
    q_cmd.color   = cell_color;
    q_addr        = AW'(lin);
    case (op)
      OP_BLIT: begin
        q_cmd.kind = KIND_BLIT;
        q_cmd.wr   = loc_ok && !skip;
        q_cmd.clip = !loc_ok;
      end
      OP_POINT: begin
        q_cmd.kind = KIND_POINT;
        q_cmd.wr   = loc_ok;
        q_cmd.clip = !loc_ok;
      end
      OP_READ: begin
        q_cmd.kind = KIND_READ;
        q_cmd.clip = !rd_ok;
        q_addr     = AW'(read_index);
      end
      default: begin
        q_cmd.kind = KIND_NOP;
      end
    endcase
  end

endmodule

FILE: hdl/tcsb_back.sv
// Back end: clearing pass, cell store read-modify-write and result register.
module tcsb_back import tcsb_pkg::*; #(
  parameter int STORE_CELLS = 8192
) (
  input  logic                           clk,
  input  logic                           rst,
  // queue head
  input  logic                           q_valid,
  output logic                           q_ready,
  input  cmd_t                           q_cmd,
  input  logic [$clog2(STORE_CELLS)-1:0] q_addr,
  // results
  output logic                           out_valid,
  input  logic                           out_ready,
  output res_t                           out_res,
  // store clearing in progress
  output logic                           clearing
);

  localparam int AW = $clog2(STORE_CELLS);

  logic [AW-1:0]     clr_addr;
  logic              s1_valid;
  cmd_t              s1_cmd;
  logic [AW-1:0]     s1_addr;
  logic              fwd_hit;
  logic [WORD_W-1:0] fwd_data;

  logic              out_free;
  logic              s1_free;
  logic              s1_done;
  logic              pop;
  logic              wr_now;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] old_word;
  logic [WORD_W-1:0] new_word;
  logic [CHAR_W-1:0] new_char;
  logic [COLOR_W-1:0] new_color;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  res_t              res;

  // Handshake between queue, work stage and result register
  assign out_free = !out_valid || out_ready;
  assign s1_done  = s1_valid && out_free;
  assign s1_free  = !s1_valid || out_free;
  assign pop      = q_valid && s1_free && !clearing;
  assign q_ready  = s1_free && !clearing;
  assign wr_now   = s1_done && s1_cmd.wr;

  // Clearing pass after reset, one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(STORE_CELLS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Merge: newest contents come from the write done at the pop edge
  assign old_word  = fwd_hit ? fwd_data : rdata;
  assign new_color = s1_cmd.fg_only ?
                     {old_word[COLOR_W-1:4], s1_cmd.color[3:0]} : s1_cmd.color;
  assign new_char  = (s1_cmd.kind == KIND_BLIT) ? s1_cmd.chr : old_word[WORD_W-1:COLOR_W];
  assign new_word  = {new_char, new_color};

  // Store write port
  assign ram_we    = clearing || wr_now;
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : new_word;

  tcsb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (q_addr),
    .rdata (rdata)
  );

  // Work stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cmd   <= q_cmd;
      s1_addr  <= q_addr;
      fwd_hit  <= wr_now && (s1_addr == q_addr);
      fwd_data <= new_word;
    end
  end

  // Result of the item in the work stage
  always_comb begin
    res.clipped    = s1_cmd.clip;
    res.written    = s1_cmd.wr;
    res.read_char  = '0;
    res.read_color = '0;
    if ((s1_cmd.kind == KIND_READ) && !s1_cmd.clip) begin
      res.read_char  = old_word[WORD_W-1:COLOR_W];
      res.read_color = old_word[COLOR_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_res <= res;
    end
  end

endmodule

FILE: hdl/text_cell_sprite_blitter_core.sv
// Top level of the text cell sprite blitter: front end, queue and back end.
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         tvalid/tready             op in tuser, cells and points in tdata
// m_axis    out        tvalid/tready             read data and write/clip flags in tdata
// cfg       in         cfg_we, no wait           register index and data
//
// One item per clock sustained while m_axis_tready is high; an accepted item goes
// through the queue, the work stage and the result register before m_axis_tvalid
// rises for it. The store has one write and one read port; a write followed at once
// by an access to the same cell is served by forwarding, so it needs no stall. After
// reset a clearing pass writes zero to every cell while s_axis_tready stays low;
// cfg writes are taken. A stall on m_axis backs up through the queue to s_axis_tready.
module text_cell_sprite_blitter_core import tcsb_pkg::*; #(
  parameter int STORE_CELLS = 8192,
  parameter int MAX_COLUMNS = 128
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // cell_char, cell_color, point_x, point_y, read_index
  input  logic [1:0]  s_axis_tuser,   // op
  input  logic        s_axis_tlast,   // last_cell
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // read_char, read_color, written, clipped
);

  localparam int AW          = $clog2(STORE_CELLS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QW          = $bits(cmd_t) + AW;

  logic          f_valid;
  logic          f_ready;
  cmd_t          f_cmd;
  logic [AW-1:0] f_addr;
  logic          b_valid;
  logic          b_ready;
  logic [QW-1:0] b_data;
  cmd_t          b_cmd;
  logic [AW-1:0] b_addr;
  logic          clearing;
  res_t          res;

  tcsb_front #(
    .STORE_CELLS (STORE_CELLS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .op         (s_axis_tuser),
    .cell_char  (s_axis_tdata[15:0]),
    .cell_color (s_axis_tdata[23:16]),
    .last_cell  (s_axis_tlast),
    .point_x    ($signed(s_axis_tdata[32:24])),
    .point_y    ($signed(s_axis_tdata[41:33])),
    .read_index (s_axis_tdata[54:42]),
    .hold       (clearing),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_cmd      (f_cmd),
    .q_addr     (f_addr)
  );

  tcsb_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_cmd, f_addr}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  assign b_cmd  = b_data[QW-1:AW];
  assign b_addr = b_data[AW-1:0];

  tcsb_back #(
    .STORE_CELLS (STORE_CELLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_cmd     (b_cmd),
    .q_addr    (b_addr),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res),
    .clearing  (clearing)
  );

  assign m_axis_tdata = {6'b0, res.clipped, res.written, res.read_color, res.read_char};

endmodule
